// ===== design/gsl_pkg.sv =====
// Shared types and constants for the goal speed limiter.
package gsl_pkg;

    // Field widths of the request and result items.
    localparam int X_W    = 20;
    localparam int TOL_W  = 16;
    localparam int SPD_W  = 16;
    localparam int TIME_W = 24;

    // Internal widths: squared range, root, dividend, needed time and compare.
    localparam int SQ_W   = 2 * X_W;
    localparam int DIST_W = X_W;
    localparam int NUM_W  = 30;
    localparam int NEED_W = 32;
    localparam int CMP_W  = NEED_W + 2;

    // Milliseconds per second, used to scale the distance.
    localparam int MS_PER_S = 1000;

    // One goal request.
    typedef struct packed {
        logic signed [X_W-1:0]    goal_x;
        logic signed [X_W-1:0]    goal_y;
        logic [TOL_W-1:0]         tolerance_mm;
        logic [SPD_W-1:0]         max_speed;
        logic signed [TIME_W-1:0] time_left_ms;
    } goal_t;

    // One result.
    typedef struct packed {
        logic [SPD_W-1:0]  limited_speed;
        logic [TIME_W-1:0] needed_time_ms;
        logic [TIME_W-1:0] behind_ms;
        logic              late;
    } result_t;

    // Fields that ride along with the square root pipeline.
    typedef struct packed {
        logic [TOL_W-1:0]         tolerance_mm;
        logic [SPD_W-1:0]         max_speed;
        logic signed [TIME_W-1:0] time_left_ms;
    } side_t;

    // Fields that ride along with the needed-time divider.
    typedef struct packed {
        logic             dist_zero;
        logic [SPD_W-1:0] max_speed;
    } div_side_t;

endpackage

// ===== design/goal_speed_limiter.sv =====
// Top level of the goal speed limiter pipeline.
//
// Each goal request carries a relative position, a goal radius, a maximum
// speed and the time left. The block returns one result per request: the
// limited speed, the time needed at full speed, the lateness and a late flag.
// Requests enter on goal/goal_valid/goal_stall and results leave on
// result/result_valid/result_stall; a transfer happens when valid is high and
// stall is low.
// Throughput is one request per cycle while goal_stall is low, set by the
// pipeline: one root bit per stage over 20 stages and one quotient bit per
// stage over 30 stages, with the two divisions running side by side.
// Reset clears every valid bit; no request is in flight afterward.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps moving until the one-entry skid buffer fills; goal_stall
// then rises and the whole pipeline freezes until the skid entry drains.
module goal_speed_limiter #(
    parameter logic [31:0] TIME_SAT = 32'd16777215
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             goal_valid,
    output logic             goal_stall,
    input  gsl_pkg::goal_t   goal,
    output logic             result_valid,
    input  logic             result_stall,
    output gsl_pkg::result_t result
);

    localparam int SIDE_W = $bits(gsl_pkg::side_t);
    localparam int DSIDE_W = $bits(gsl_pkg::div_side_t);
    localparam int TDEN_W = gsl_pkg::TIME_W - 1;

    logic hold;
    logic advance;

    // Stage 1: absolute offsets.
    logic                        v1_reg;
    logic [gsl_pkg::X_W-1:0]     ax1_reg;
    logic [gsl_pkg::X_W-1:0]     ay1_reg;
    gsl_pkg::side_t              side1_reg;
    logic [gsl_pkg::X_W-1:0]     ax1_next;
    logic [gsl_pkg::X_W-1:0]     ay1_next;
    gsl_pkg::side_t              side1_next;

    // Stage 2: squares.
    logic                        v2_reg;
    logic [gsl_pkg::SQ_W-1:0]    xx2_reg;
    logic [gsl_pkg::SQ_W-1:0]    yy2_reg;
    gsl_pkg::side_t              side2_reg;

    // Stage 3: squared range.
    logic                        v3_reg;
    logic [gsl_pkg::SQ_W-1:0]    sq3_reg;
    gsl_pkg::side_t              side3_reg;

    // Square root outputs.
    logic                        v4;
    logic [gsl_pkg::DIST_W-1:0]  root4;
    logic [SIDE_W-1:0]           side4_bits;
    gsl_pkg::side_t              side4;

    // Stage 5: distance to the goal border.
    logic                        v5_reg;
    logic [gsl_pkg::DIST_W-1:0]  d5_reg;
    gsl_pkg::side_t              side5_reg;
    logic [gsl_pkg::DIST_W-1:0]  d5_next;

    // Stage 6: distance scaled to the dividend.
    logic                        v6_reg;
    logic [gsl_pkg::NUM_W-1:0]   num6_reg;
    logic                        dz6_reg;
    gsl_pkg::side_t              side6_reg;
    gsl_pkg::div_side_t          dside6;

    // Divider outputs.
    logic                        v_need;
    logic                        v_lim;
    logic [gsl_pkg::NUM_W-1:0]   q_need;
    logic [gsl_pkg::NUM_W-1:0]   q_lim;
    logic [DSIDE_W-1:0]          dside_bits;
    gsl_pkg::div_side_t          dside;
    logic [gsl_pkg::TIME_W-1:0]  tleft_bits;

    // Stage 7: needed time.
    logic                             v7_reg;
    logic [gsl_pkg::NEED_W-1:0]       need7_reg;
    logic [gsl_pkg::SPD_W-1:0]        spd7_reg;
    logic signed [gsl_pkg::TIME_W-1:0] tleft7_reg;
    logic [gsl_pkg::NUM_W-1:0]        qlim7_reg;
    logic [gsl_pkg::NEED_W-1:0]       need7_next;
    logic [gsl_pkg::NEED_W-1:0]       qneed_ext;

    // Stage 8: final decision.
    logic                        v8_reg;
    gsl_pkg::result_t            res8_reg;
    gsl_pkg::result_t            res8_next;
    logic [gsl_pkg::CMP_W-1:0]   tleft_ext;
    logic [gsl_pkg::CMP_W-1:0]   need_ext;
    logic [gsl_pkg::CMP_W-1:0]   diff;
    logic                        late;

    assign advance    = !hold;
    assign goal_stall = hold;

    // Stage 1 logic: absolute values and side fields.
    always_comb
    begin
        ax1_next = goal.goal_x[gsl_pkg::X_W-1] ?
                   gsl_pkg::X_W'(~goal.goal_x) + gsl_pkg::X_W'(1) : goal.goal_x;
        ay1_next = goal.goal_y[gsl_pkg::X_W-1] ?
                   gsl_pkg::X_W'(~goal.goal_y) + gsl_pkg::X_W'(1) : goal.goal_y;
        side1_next.tolerance_mm = goal.tolerance_mm;
        side1_next.max_speed    = goal.max_speed;
        side1_next.time_left_ms = goal.time_left_ms;
    end

    // Stage 5 logic: root minus radius, floored at zero.
    always_comb
    begin
        if (root4 > gsl_pkg::DIST_W'(side4.tolerance_mm))
        begin
            d5_next = root4 - gsl_pkg::DIST_W'(side4.tolerance_mm);
        end
        else
        begin
            d5_next = '0;
        end
    end

    // Stage 7 logic: needed time, saturated.
    assign qneed_ext = gsl_pkg::NEED_W'(q_need);

    always_comb
    begin
        priority if (dside.dist_zero)
        begin
            need7_next = '0;
        end
        else if (dside.max_speed == '0)
        begin
            need7_next = TIME_SAT;
        end
        else if (qneed_ext > TIME_SAT)
        begin
            need7_next = TIME_SAT;
        end
        else
        begin
            need7_next = qneed_ext;
        end
    end

    // Stage 8 logic: late check, lateness and speed limit.
    always_comb
    begin
        tleft_ext = {{(gsl_pkg::CMP_W - gsl_pkg::TIME_W){tleft7_reg[gsl_pkg::TIME_W-1]}},
                     tleft7_reg};
        need_ext  = {2'b00, need7_reg};
        diff      = need_ext - tleft_ext;
        late      = !($signed(tleft_ext) > $signed(need_ext));
        res8_next.needed_time_ms = need7_reg[gsl_pkg::TIME_W-1:0];
        res8_next.late           = late;
        if (late)
        begin
            res8_next.limited_speed = spd7_reg;
            if (|diff[gsl_pkg::CMP_W-1:gsl_pkg::TIME_W])
            begin
                res8_next.behind_ms = '1;
            end
            else
            begin
                res8_next.behind_ms = diff[gsl_pkg::TIME_W-1:0];
            end
        end
        else
        begin
            res8_next.behind_ms = '0;
            if (qlim7_reg > gsl_pkg::NUM_W'(spd7_reg))
            begin
                res8_next.limited_speed = spd7_reg;
            end
            else
            begin
                res8_next.limited_speed = qlim7_reg[gsl_pkg::SPD_W-1:0];
            end
        end
    end

    // Valid bits of the local stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= goal_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v5_reg <= v4;
            v6_reg <= v5_reg;
            v7_reg <= v_need && v_lim;
            v8_reg <= v7_reg;
        end
    end

    // Data of the local stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax1_reg    <= ax1_next;
            ay1_reg    <= ay1_next;
            side1_reg  <= side1_next;
            xx2_reg    <= gsl_pkg::SQ_W'(ax1_reg) * gsl_pkg::SQ_W'(ax1_reg);
            yy2_reg    <= gsl_pkg::SQ_W'(ay1_reg) * gsl_pkg::SQ_W'(ay1_reg);
            side2_reg  <= side1_reg;
            sq3_reg    <= gsl_pkg::SQ_W'(xx2_reg + yy2_reg);
            side3_reg  <= side2_reg;
            d5_reg     <= d5_next;
            side5_reg  <= side4;
            num6_reg   <= gsl_pkg::NUM_W'(d5_reg * gsl_pkg::NUM_W'(gsl_pkg::MS_PER_S));
            dz6_reg    <= (d5_reg == '0);
            side6_reg  <= side5_reg;
            need7_reg  <= need7_next;
            spd7_reg   <= dside.max_speed;
            tleft7_reg <= tleft_bits;
            qlim7_reg  <= q_lim;
            res8_reg   <= res8_next;
        end
    end

    // Square root of the squared range.
    gsl_isqrt #(
        .IN_W  (gsl_pkg::SQ_W),
        .PAY_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v3_reg),
        .radicand  (sq3_reg),
        .in_pay    (side3_reg),
        .out_valid (v4),
        .root      (root4),
        .out_pay   (side4_bits)
    );

    assign side4 = gsl_pkg::side_t'(side4_bits);

    // Needed time: scaled distance over maximum speed.
    always_comb
    begin
        dside6.dist_zero = dz6_reg;
        dside6.max_speed = side6_reg.max_speed;
    end

    gsl_div #(
        .NUM_W (gsl_pkg::NUM_W),
        .DEN_W (gsl_pkg::SPD_W),
        .PAY_W (DSIDE_W)
    ) u_div_need (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v6_reg),
        .dividend  (num6_reg),
        .divisor   (side6_reg.max_speed),
        .in_pay    (dside6),
        .out_valid (v_need),
        .quotient  (q_need),
        .out_pay   (dside_bits)
    );

    assign dside = gsl_pkg::div_side_t'(dside_bits);

    // Scaled speed: scaled distance over time left (used only when positive).
    gsl_div #(
        .NUM_W (gsl_pkg::NUM_W),
        .DEN_W (TDEN_W),
        .PAY_W (gsl_pkg::TIME_W)
    ) u_div_lim (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v6_reg),
        .dividend  (num6_reg),
        .divisor   (side6_reg.time_left_ms[TDEN_W-1:0]),
        .in_pay    (side6_reg.time_left_ms),
        .out_valid (v_lim),
        .quotient  (q_lim),
        .out_pay   (tleft_bits)
    );

    // Output register and skid buffer.
    gsl_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (v8_reg && advance),
        .item         (res8_reg),
        .hold         (hold),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

// ===== design/gsl_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module gsl_isqrt #(
    parameter int IN_W  = 40,
    parameter int PAY_W = 56
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     radicand,
    input  logic [PAY_W-1:0]    in_pay,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   root,
    output logic [PAY_W-1:0]    out_pay
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 1;

    logic              v_reg    [ROOT_W];
    logic [IN_W-1:0]   n_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [PAY_W-1:0]  pay_reg  [ROOT_W];

    logic              v_src    [ROOT_W];
    logic [IN_W-1:0]   n_src    [ROOT_W];
    logic [REM_W-1:0]  rem_src  [ROOT_W];
    logic [ROOT_W-1:0] root_src [ROOT_W];
    logic [PAY_W-1:0]  pay_src  [ROOT_W];

    logic [IN_W-1:0]   n_next    [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    genvar g;
    generate
        for (g = 0; g < ROOT_W; g++)
        begin : g_stage
            logic [REM_W+1:0] cand;
            logic [REM_W+1:0] trial;
            logic             fits;

            // Stage input comes from the ports or from the previous stage.
            if (g == 0)
            begin : g_first
                assign v_src[g]    = in_valid;
                assign n_src[g]    = radicand;
                assign rem_src[g]  = '0;
                assign root_src[g] = '0;
                assign pay_src[g]  = in_pay;
            end
            else
            begin : g_rest
                assign v_src[g]    = v_reg[g-1];
                assign n_src[g]    = n_reg[g-1];
                assign rem_src[g]  = rem_reg[g-1];
                assign root_src[g] = root_reg[g-1];
                assign pay_src[g]  = pay_reg[g-1];
            end

            // Bring down the next bit pair and try the next root bit.
            always_comb
            begin
                cand  = {rem_src[g], n_src[g][IN_W-1 -: 2]};
                trial = {{(REM_W - ROOT_W){1'b0}}, root_src[g], 2'b01};
                fits  = (cand >= trial);
                rem_next[g]  = fits ? REM_W'(cand - trial) : REM_W'(cand);
                root_next[g] = {root_src[g][ROOT_W-2:0], fits};
                n_next[g]    = {n_src[g][IN_W-3:0], 2'b00};
            end

            // Valid bit of the stage.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g] <= 1'b0;
                end
                else if (advance)
                begin
                    v_reg[g] <= v_src[g];
                end
            end

            // Data of the stage.
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    n_reg[g]    <= n_next[g];
                    rem_reg[g]  <= rem_next[g];
                    root_reg[g] <= root_next[g];
                    pay_reg[g]  <= pay_src[g];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_pay   = pay_reg[ROOT_W-1];

endmodule

// ===== design/gsl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module gsl_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 16,
    parameter int PAY_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [NUM_W-1:0] quotient,
    output logic [PAY_W-1:0] out_pay
);

    logic             v_reg   [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [PAY_W-1:0] pay_reg [NUM_W];

    logic             v_src   [NUM_W];
    logic [NUM_W-1:0] nq_src  [NUM_W];
    logic [DEN_W-1:0] rem_src [NUM_W];
    logic [DEN_W-1:0] den_src [NUM_W];
    logic [PAY_W-1:0] pay_src [NUM_W];

    logic [NUM_W-1:0] nq_next  [NUM_W];
    logic [DEN_W-1:0] rem_next [NUM_W];

    genvar g;
    generate
        for (g = 0; g < NUM_W; g++)
        begin : g_stage
            logic [DEN_W:0] cand;
            logic           fits;

            // Stage input comes from the ports or from the previous stage.
            if (g == 0)
            begin : g_first
                assign v_src[g]   = in_valid;
                assign nq_src[g]  = dividend;
                assign rem_src[g] = '0;
                assign den_src[g] = divisor;
                assign pay_src[g] = in_pay;
            end
            else
            begin : g_rest
                assign v_src[g]   = v_reg[g-1];
                assign nq_src[g]  = nq_reg[g-1];
                assign rem_src[g] = rem_reg[g-1];
                assign den_src[g] = den_reg[g-1];
                assign pay_src[g] = pay_reg[g-1];
            end

            // Shift in the next dividend bit and subtract where it fits.
            // The dividend shifts out at the top while quotient bits enter below.
            always_comb
            begin
                cand = {rem_src[g], nq_src[g][NUM_W-1]};
                fits = (cand >= {1'b0, den_src[g]});
                rem_next[g] = fits ? DEN_W'(cand - {1'b0, den_src[g]}) : DEN_W'(cand);
                nq_next[g]  = {nq_src[g][NUM_W-2:0], fits};
            end

            // Valid bit of the stage.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g] <= 1'b0;
                end
                else if (advance)
                begin
                    v_reg[g] <= v_src[g];
                end
            end

            // Data of the stage.
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    nq_reg[g]  <= nq_next[g];
                    rem_reg[g] <= rem_next[g];
                    den_reg[g] <= den_src[g];
                    pay_reg[g] <= pay_src[g];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NUM_W-1];
    assign quotient  = nq_reg[NUM_W-1];
    assign out_pay   = pay_reg[NUM_W-1];

endmodule

// ===== design/gsl_out.sv =====
// Output register with a one-entry skid buffer.
module gsl_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  gsl_pkg::result_t item,
    output logic             hold,
    output logic             result_valid,
    output gsl_pkg::result_t result,
    input  logic             result_stall
);

    logic             out_valid_reg;
    logic             out_valid_next;
    gsl_pkg::result_t out_data_reg;
    gsl_pkg::result_t out_data_next;
    logic             skid_full_reg;
    logic             skid_full_next;
    gsl_pkg::result_t skid_data_reg;
    gsl_pkg::result_t skid_data_next;
    logic             out_free;

    // The output register can load when it is empty or being taken.
    assign out_free = !out_valid_reg || !result_stall;

    // Route an arriving request to the output or to the skid entry.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        skid_full_next = skid_full_reg;
        skid_data_next = skid_data_reg;
        priority if (skid_full_reg)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = skid_data_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (item_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = item;
            end
            else
            begin
                skid_full_next = 1'b1;
                skid_data_next = item;
            end
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign hold         = skid_full_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// ===== tb/goal_speed_limiter_test.sv =====
// Self-checking testbench for the goal speed limiter: directed goals, then random goals.
module goal_speed_limiter_test;

    localparam longint TIME_SAT_MS  = 64'd16777215;
    localparam longint BEHIND_MAX   = 64'd16777215;
    localparam longint TLEFT_MAX    = 64'd8388607;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 100;

    // One directed row: a goal and, where it is obvious, its result typed in.
    typedef struct {
        gsl_pkg::goal_t   req;
        bit               typed;
        gsl_pkg::result_t res;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             goal_valid;
    logic             goal_stall;
    gsl_pkg::goal_t   goal;
    logic             result_valid;
    logic             result_stall;
    gsl_pkg::result_t result;

    gsl_pkg::result_t expected_results[$];
    stim_row_t        directed_rows[$];
    gsl_pkg::result_t want;
    int               send_idle_pct;
    int               recv_stall_pct;
    bit               hold_request;
    int               goals_sent;
    int               results_checked;
    int               late_results;
    int               input_stall_cycles;
    int               failures;
    int               cycle_count;

    goal_speed_limiter #(
        .TIME_SAT(32'd16777215)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .goal_valid(goal_valid),
        .goal_stall(goal_stall),
        .goal(goal),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Computes the speed limit, needed time and lateness for one goal.
    function automatic gsl_pkg::result_t limit_goal_speed(gsl_pkg::goal_t g);
        longint           ax;
        longint           ay;
        longint           tl;
        longint           span_mm;
        longint           need;
        longint           lim;
        longint           diff;
        longint unsigned  rem;
        longint unsigned  root;
        longint unsigned  probe;
        gsl_pkg::result_t r;
        ax = g.goal_x;
        ay = g.goal_y;
        tl = g.time_left_ms;
        if (ax < 0)
            ax = -ax;
        if (ay < 0)
            ay = -ay;

        // Bitwise integer square root of the squared range.
        rem   = ax * ax + ay * ay;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end

        // Distance left to the border of the goal area.
        span_mm = (longint'(root) > longint'(g.tolerance_mm)) ?
                  longint'(root) - longint'(g.tolerance_mm) : 0;

        // Time needed at full speed, saturated.
        if (span_mm == 0)
            need = 0;
        else if (g.max_speed == 0)
            need = TIME_SAT_MS;
        else
        begin
            need = (span_mm * gsl_pkg::MS_PER_S) / longint'(g.max_speed);
            if (need > TIME_SAT_MS)
                need = TIME_SAT_MS;
        end

        // Either scale the speed down or report how late the robot is.
        if (tl > need)
        begin
            lim = (span_mm * gsl_pkg::MS_PER_S) / tl;
            if (lim > longint'(g.max_speed))
                lim = g.max_speed;
            r.limited_speed = gsl_pkg::SPD_W'(lim);
            r.behind_ms     = '0;
            r.late          = 1'b0;
        end
        else
        begin
            diff = need - tl;
            if (diff > BEHIND_MAX)
                diff = BEHIND_MAX;
            r.limited_speed = g.max_speed;
            r.behind_ms     = gsl_pkg::TIME_W'(diff);
            r.late          = 1'b1;
        end
        r.needed_time_ms = gsl_pkg::TIME_W'(need);
        return r;
    endfunction

    // Draws one goal, mostly from regions where the arithmetic gets interesting.
    function automatic gsl_pkg::goal_t random_goal();
        gsl_pkg::goal_t   g;
        gsl_pkg::result_t r;
        longint           tl;
        int               kind;
        kind = $urandom_range(9);
        g = gsl_pkg::goal_t'({$urandom, $urandom, $urandom});
        case (kind)
            3, 4:
            begin
                // Short distances around a modest goal area.
                g.goal_x       = gsl_pkg::X_W'(int'($urandom_range(4000)) - 2000);
                g.goal_y       = gsl_pkg::X_W'(int'($urandom_range(4000)) - 2000);
                g.tolerance_mm = gsl_pkg::TOL_W'($urandom_range(3000));
                g.max_speed    = gsl_pkg::SPD_W'($urandom_range(2000));
                g.time_left_ms = gsl_pkg::TIME_W'(int'($urandom_range(25000)) - 5000);
            end
            5, 6:
            begin
                // Time left lands right around the needed time.
                g.goal_x       = gsl_pkg::X_W'(int'($urandom_range(200000)) - 100000);
                g.goal_y       = gsl_pkg::X_W'(int'($urandom_range(200000)) - 100000);
                g.tolerance_mm = gsl_pkg::TOL_W'($urandom_range(5000));
                g.max_speed    = gsl_pkg::SPD_W'($urandom_range(65535, 1));
                g.time_left_ms = '0;
                r  = limit_goal_speed(g);
                tl = longint'(r.needed_time_ms) + longint'($urandom_range(4)) - 2;
                if (tl > TLEFT_MAX)
                    tl = TLEFT_MAX;
                g.time_left_ms = gsl_pkg::TIME_W'(tl);
            end
            7:
            begin
                g.max_speed = '0;
            end
            8:
            begin
                // Well inside the largest goal area.
                g.goal_x       = gsl_pkg::X_W'(int'($urandom_range(80000)) - 40000);
                g.goal_y       = gsl_pkg::X_W'(int'($urandom_range(80000)) - 40000);
                g.tolerance_mm = '1;
            end
            9:
            begin
                g.time_left_ms[gsl_pkg::TIME_W-1] = 1'b1;
            end
            default:
            begin
            end
        endcase
        return g;
    endfunction

    // Adds one directed row; the result fields count only when typed is set.
    task automatic add_row(input int x, input int y, input int tol, input int spd,
                           input int tleft, input bit typed, input int lim = 0,
                           input int need = 0, input int behind = 0, input bit late = 0);
        stim_row_t row;
        row.req.goal_x         = gsl_pkg::X_W'(x);
        row.req.goal_y         = gsl_pkg::X_W'(y);
        row.req.tolerance_mm   = gsl_pkg::TOL_W'(tol);
        row.req.max_speed      = gsl_pkg::SPD_W'(spd);
        row.req.time_left_ms   = gsl_pkg::TIME_W'(tleft);
        row.typed              = typed;
        row.res.limited_speed  = gsl_pkg::SPD_W'(lim);
        row.res.needed_time_ms = gsl_pkg::TIME_W'(need);
        row.res.behind_ms      = gsl_pkg::TIME_W'(behind);
        row.res.late           = late;
        directed_rows.push_back(row);
    endtask

    // Offers one request until it is taken, then idles at random.
    task automatic send_goal(input gsl_pkg::goal_t g, input bit typed,
                             input gsl_pkg::result_t typed_res);
        goal       <= g;
        goal_valid <= 1'b1;
        do
            @(posedge clk);
        while (goal_stall);
        expected_results.push_back(typed ? typed_res : limit_goal_speed(g));
        goals_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            goal_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain_results();
        goal_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            send_goal(random_goal(), 1'b0, '0);
        drain_results();
    endtask

    // Receiver: random stalls, plus a long hold-off counted here on request.
    initial
    begin : receiver
        int hold_count;
        hold_count   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_count   = HOLD_CYCLES;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Checks every result taken against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: %p", result);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (result.late)
                    late_results++;
                if (result.limited_speed !== want.limited_speed)
                begin
                    $error("limited_speed: expected %0d, got %0d",
                           want.limited_speed, result.limited_speed);
                    failures++;
                end
                if (result.needed_time_ms !== want.needed_time_ms)
                begin
                    $error("needed_time_ms: expected %0d, got %0d",
                           want.needed_time_ms, result.needed_time_ms);
                    failures++;
                end
                if (result.behind_ms !== want.behind_ms)
                begin
                    $error("behind_ms: expected %0d, got %0d",
                           want.behind_ms, result.behind_ms);
                    failures++;
                end
                if (result.late !== want.late)
                begin
                    $error("late: expected %0d, got %0d", want.late, result.late);
                    failures++;
                end
            end
        end
        if (rst_n && goal_valid && goal_stall)
            input_stall_cycles++;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        goal_valid     = 1'b0;
        goal           = '0;
        hold_request   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // Directed goals: extremes of every field and the special cases.
        // Inside the goal area: no distance, so the speed limit drops to zero.
        add_row(0, 0, 0, 100, 1000, 1'b1, 0, 0, 0, 1'b0);
        add_row(-3000, -4000, 5000, 200, 100, 1'b1, 0, 0, 0, 1'b0);
        add_row(0, 0, 65535, 65535, 8388607, 1'b1, 0, 0, 0, 1'b0);
        // No time left at the border itself counts as late by nothing.
        add_row(0, 0, 0, 100, 0, 1'b1, 100, 0, 0, 1'b1);
        // Zero speed away from the goal takes forever.
        add_row(3000, 4000, 0, 0, 1000, 1'b1, 0, 16777215, 16776215, 1'b1);
        add_row(3000, 4000, 0, 0, -8388608, 1'b1, 0, 16777215, 16777215, 1'b1);
        add_row(0, 524287, 65535, 0, 8388607, 1'b0);
        // Most negative time left, counted in full as lateness.
        add_row(0, 0, 0, 65535, -8388608, 1'b1, 65535, 0, 8388608, 1'b1);
        add_row(1, 1, 0, 1, -1, 1'b1, 1, 1000, 1001, 1'b1);
        // Scaling down, exactly on time, and behind schedule.
        add_row(1000, 0, 0, 1000, 2000, 1'b1, 500, 1000, 0, 1'b0);
        add_row(1000, 0, 0, 1000, 1000, 1'b1, 1000, 1000, 0, 1'b1);
        add_row(1000, 0, 0, 1000, 500, 1'b1, 1000, 1000, 500, 1'b1);
        add_row(-3000, 4000, 4999, 1, 8388607, 1'b1, 0, 1000, 0, 1'b0);
        // Needed time saturates at the slowest speed.
        add_row(-524288, 0, 0, 1, 0, 1'b1, 1, 16777215, 16777215, 1'b1);
        // Corners of the position range.
        add_row(-524288, -524288, 0, 1, 8388607, 1'b0);
        add_row(524287, 524287, 0, 65535, 8388607, 1'b0);
        add_row(524287, -524288, 65535, 65535, 1, 1'b0);
        add_row(-524288, 524287, 65535, 1, -8388608, 1'b0);
        add_row(100, 0, 0, 65535, 8388607, 1'b0);
        add_row(2000, 0, 0, 500, 3000, 1'b0);
        add_row(5, 12, 0, 13000, 2, 1'b0);
        add_row(-7, 24, 24, 65535, 1, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_goal(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
        drain_results();

        // Random goals under each idling pattern.
        run_phase(300, 0, 0);
        run_phase(250, 71, 0);
        run_phase(250, 0, 71);
        run_phase(250, 26, 26);

        // Back pressure: the receiver holds off while requests keep coming.
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        run_phase(200, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results for %0d goals (%0d late) in %0d cycles.",
                 results_checked, goals_sent, late_results, cycle_count);
        $display("Idle and stall patterns plus a long hold-off; input stalled %0d cycles.",
                 input_stall_cycles);
        if (failures == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
